[rtl/core/dla_pkg.sv]
// shared types and codes for the dhcp lease allocator
package dla_pkg;

    // operation codes
    localparam logic [1:0] OP_DISCOVER = 2'd0;
    localparam logic [1:0] OP_REQUEST  = 2'd1;
    localparam logic [1:0] OP_RESERVE  = 2'd2;
    localparam logic [1:0] OP_REMOVE   = 2'd3;

    // reply codes
    localparam logic [1:0] RPL_NONE  = 2'd0;
    localparam logic [1:0] RPL_OFFER = 2'd1;
    localparam logic [1:0] RPL_ACK   = 2'd2;
    localparam logic [1:0] RPL_NAK   = 2'd3;

    // register indexes
    localparam logic [2:0] REG_SERVER  = 3'd0;
    localparam logic [2:0] REG_FIRST   = 3'd1;
    localparam logic [2:0] REG_LAST    = 3'd2;
    localparam logic [2:0] REG_MASK    = 3'd3;
    localparam logic [2:0] REG_GATEWAY = 3'd4;
    localparam logic [2:0] REG_ENABLE  = 3'd5;

    localparam int ADDR_W = 5;

    // configuration seen by the sequencer
    typedef struct packed {
        logic [31:0] srv_ip;
        logic [31:0] pool_lo;
        logic [31:0] pool_hi;
        logic        service_ok;
    } cfg_t;

endpackage

[rtl/core/dla_req_if.sv]
// request channel carrying one lease operation per beat
interface dla_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [47:0] hw_addr;
    logic [31:0] address;
    logic [31:0] server_id;
    logic [31:0] xact_id;

    modport source (output valid, op, hw_addr, address, server_id, xact_id,
                    input ready);
    modport sink (input valid, op, hw_addr, address, server_id, xact_id,
                  output ready);
endinterface

[rtl/core/dla_rsp_if.sv]
// reply channel carrying one result per beat
interface dla_rsp_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [1:0]  reply_type;
    logic [31:0] reply_transaction;
    logic [47:0] reply_mac;
    logic [31:0] lease_address;

    modport source (output valid, accepted, reply_type, reply_transaction, reply_mac,
                    lease_address, input ready);
    modport sink (input valid, accepted, reply_type, reply_transaction, reply_mac,
                  lease_address, output ready);
endinterface

[rtl/core/dla_cfg.sv]
// apb register file and configuration consistency check
module dla_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dla_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output dla_pkg::cfg_t              cfg
);

    logic [31:0] server_reg;
    logic [31:0] first_reg;
    logic [31:0] last_reg;
    logic [31:0] mask_reg;
    logic [31:0] gateway_reg;
    logic        enable_reg;
    logic [2:0]  reg_idx;
    logic [31:0] inv_mask;
    logic        mask_ok;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_reg  <= '0;
            first_reg   <= '0;
            last_reg    <= '0;
            mask_reg    <= '0;
            gateway_reg <= '0;
            enable_reg  <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                dla_pkg::REG_SERVER:  server_reg  <= pwdata;
                dla_pkg::REG_FIRST:   first_reg   <= pwdata;
                dla_pkg::REG_LAST:    last_reg    <= pwdata;
                dla_pkg::REG_MASK:    mask_reg    <= pwdata;
                dla_pkg::REG_GATEWAY: gateway_reg <= pwdata;
                dla_pkg::REG_ENABLE:  enable_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            dla_pkg::REG_SERVER:  prdata = server_reg;
            dla_pkg::REG_FIRST:   prdata = first_reg;
            dla_pkg::REG_LAST:    prdata = last_reg;
            dla_pkg::REG_MASK:    prdata = mask_reg;
            dla_pkg::REG_GATEWAY: prdata = gateway_reg;
            dla_pkg::REG_ENABLE:  prdata = {31'd0, enable_reg};
            default:              prdata = '0;
        endcase
    end

    // consistency: enable set, contiguous mask, shared subnet, ordered pool, nonzero server
    assign inv_mask = ~mask_reg;
    assign mask_ok  = (inv_mask & (inv_mask + 32'd1)) == 32'd0;

    assign cfg.srv_ip     = server_reg;
    assign cfg.pool_lo    = first_reg;
    assign cfg.pool_hi    = last_reg;
    assign cfg.service_ok = enable_reg && (server_reg != 32'd0)
                            && (first_reg <= last_reg) && mask_ok
                            && ((server_reg & mask_reg) == (first_reg & mask_reg))
                            && ((server_reg & mask_reg) == (last_reg & mask_reg))
                            && ((gateway_reg == 32'd0)
                                || ((server_reg & mask_reg) == (gateway_reg & mask_reg)));

endmodule

[rtl/core/dhcp_lease_allocator_top.sv]
// dhcp lease table: sequencer, lease memory and reply register
// discover with a new client runs a pool scan that walks candidate addresses
// and rescans the lease memory for each one
// one item in flight, ready only when idle; a result waits in the output register
// rst_n clears count, sequencer and reply registers at once; payload latch and lease memory are not cleared
module dhcp_lease_allocator_top #(
    parameter int LEASE_SLOTS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    dla_req_if.sink                    req,
    dla_rsp_if.source                  rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dla_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int IDX_W = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;
    localparam int CNT_W = $clog2(LEASE_SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_RD, S_CMP, S_END, S_POOL, S_MOVE, S_MOVE2, S_WRITE, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        P_DMAC, P_POOL, P_REQ, P_RADDR, P_RMAC, P_REM
    } phase_t;

    dla_pkg::cfg_t cfg;

    state_t      state_reg;
    phase_t      phase_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic        hit_ok_reg;
    logic [31:0] hit_addr_reg;
    logic [IDX_W-1:0] own_idx_reg;
    logic        own_ok_reg;
    logic [31:0] cand_reg;

    logic [1:0]  op_reg;
    logic [47:0] mac_reg;
    logic [31:0] addr_reg;
    logic [31:0] sid_reg;
    logic [31:0] xid_reg;

    logic        res_acc_reg;
    logic [1:0]  res_type_reg;
    logic [31:0] res_lease_reg;

    logic        we_mac_reg;
    logic        we_addr_reg;
    logic [IDX_W-1:0] wr_idx_reg;
    logic [47:0] wr_mac_reg;
    logic [31:0] wr_addr_reg;

    logic        out_valid_reg;
    logic        out_acc_reg;
    logic [1:0]  out_type_reg;
    logic [31:0] out_xid_reg;
    logic [47:0] out_mac_reg;
    logic [31:0] out_lease_reg;

    logic [47:0] mac_mem [LEASE_SLOTS];
    logic [31:0] addr_mem [LEASE_SLOTS];
    logic [47:0] rd_mac_reg;
    logic [31:0] rd_addr_reg;
    logic [IDX_W-1:0] ridx;
    logic [31:0] key_addr;
    logic        match;
    logic        usable;

    dla_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // lease memory: one read and one write port
    assign ridx = (state_reg == S_MOVE) ? cnt_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        rd_mac_reg  <= mac_mem[ridx];
        rd_addr_reg <= addr_mem[ridx];
        if (state_reg == S_WRITE && we_mac_reg)
        begin
            mac_mem[wr_idx_reg] <= wr_mac_reg;
        end
        if (state_reg == S_WRITE && we_addr_reg)
        begin
            addr_mem[wr_idx_reg] <= wr_addr_reg;
        end
    end

    // scan compare: mac key or address key
    assign key_addr = (phase_reg == P_POOL) ? cand_reg : addr_reg;
    assign match    = (phase_reg == P_DMAC || phase_reg == P_REQ || phase_reg == P_RMAC)
                      ? (rd_mac_reg == mac_reg) : (rd_addr_reg == key_addr);
    assign usable   = (addr_reg >= cfg.pool_lo) && (addr_reg <= cfg.pool_hi)
                      && (addr_reg != cfg.srv_ip);

    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid             = out_valid_reg;
    assign rsp.accepted          = out_acc_reg;
    assign rsp.reply_type        = out_type_reg;
    assign rsp.reply_transaction = out_xid_reg;
    assign rsp.reply_mac         = out_mac_reg;
    assign rsp.lease_address     = out_lease_reg;

    // payload latch
    always_ff @(posedge clk)
    begin
        if (req.valid && state_reg == S_IDLE)
        begin
            op_reg   <= req.op;
            mac_reg  <= req.hw_addr;
            addr_reg <= req.address;
            sid_reg  <= req.server_id;
            xid_reg  <= req.xact_id;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= P_DMAC;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            hit_idx_reg   <= '0;
            hit_ok_reg    <= 1'b0;
            hit_addr_reg  <= '0;
            own_idx_reg   <= '0;
            own_ok_reg    <= 1'b0;
            cand_reg      <= '0;
            res_acc_reg   <= 1'b0;
            res_type_reg  <= dla_pkg::RPL_NONE;
            res_lease_reg <= '0;
            we_mac_reg    <= 1'b0;
            we_addr_reg   <= 1'b0;
            wr_idx_reg    <= '0;
            wr_mac_reg    <= '0;
            wr_addr_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_acc_reg   <= 1'b0;
            out_type_reg  <= dla_pkg::RPL_NONE;
            out_xid_reg   <= '0;
            out_mac_reg   <= '0;
            out_lease_reg <= '0;
        end
        else
        begin
            // reply beat taken; a new reply in S_OUT reloads the register instead
            if (out_valid_reg && rsp.ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        state_reg <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    res_acc_reg   <= 1'b0;
                    res_type_reg  <= dla_pkg::RPL_NONE;
                    res_lease_reg <= '0;
                    idx_reg       <= '0;
                    if (op_reg == dla_pkg::OP_REMOVE)
                    begin
                        phase_reg <= P_REM;
                        state_reg <= S_RD;
                    end
                    else if (!cfg.service_ok)
                    begin
                        state_reg <= S_OUT;
                    end
                    else if (op_reg == dla_pkg::OP_DISCOVER)
                    begin
                        phase_reg <= P_DMAC;
                        state_reg <= S_RD;
                    end
                    else if (op_reg == dla_pkg::OP_REQUEST)
                    begin
                        phase_reg <= P_REQ;
                        state_reg <= (sid_reg != cfg.srv_ip) ? S_OUT : S_RD;
                    end
                    else
                    begin
                        phase_reg <= P_RADDR;
                        state_reg <= usable ? S_RD : S_OUT;
                    end
                end
                S_RD:
                begin
                    if (idx_reg >= cnt_reg)
                    begin
                        hit_ok_reg <= 1'b0;
                        state_reg  <= S_END;
                    end
                    else
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    if (match)
                    begin
                        hit_ok_reg   <= 1'b1;
                        hit_idx_reg  <= idx_reg[IDX_W-1:0];
                        hit_addr_reg <= rd_addr_reg;
                        state_reg    <= S_END;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CNT_W'(1);
                        state_reg <= S_RD;
                    end
                end
                S_END:
                begin
                    idx_reg <= '0;
                    unique case (phase_reg)
                        P_DMAC:
                        begin
                            if (hit_ok_reg)
                            begin
                                res_acc_reg   <= 1'b1;
                                res_type_reg  <= dla_pkg::RPL_OFFER;
                                res_lease_reg <= hit_addr_reg;
                                state_reg     <= S_OUT;
                            end
                            else if (cnt_reg >= CNT_W'(LEASE_SLOTS))
                            begin
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                cand_reg  <= cfg.pool_lo;
                                state_reg <= S_POOL;
                            end
                        end
                        P_POOL:
                        begin
                            if (hit_ok_reg)
                            begin
                                // candidate taken: move on or give up at the pool end
                                if (cand_reg == cfg.pool_hi)
                                begin
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    cand_reg  <= cand_reg + 32'd1;
                                    state_reg <= S_POOL;
                                end
                            end
                            else
                            begin
                                we_mac_reg    <= 1'b1;
                                we_addr_reg   <= 1'b1;
                                wr_idx_reg    <= cnt_reg[IDX_W-1:0];
                                wr_mac_reg    <= mac_reg;
                                wr_addr_reg   <= cand_reg;
                                cnt_reg       <= cnt_reg + CNT_W'(1);
                                res_acc_reg   <= 1'b1;
                                res_type_reg  <= dla_pkg::RPL_OFFER;
                                res_lease_reg <= cand_reg;
                                state_reg     <= S_WRITE;
                            end
                        end
                        P_REQ:
                        begin
                            res_acc_reg <= 1'b1;
                            if (hit_ok_reg && hit_addr_reg == addr_reg)
                            begin
                                res_type_reg  <= dla_pkg::RPL_ACK;
                                res_lease_reg <= addr_reg;
                            end
                            else
                            begin
                                res_type_reg <= dla_pkg::RPL_NAK;
                            end
                            state_reg <= S_OUT;
                        end
                        P_RADDR:
                        begin
                            own_ok_reg  <= hit_ok_reg;
                            own_idx_reg <= hit_idx_reg;
                            phase_reg   <= P_RMAC;
                            state_reg   <= S_RD;
                        end
                        P_RMAC:
                        begin
                            if (own_ok_reg && (!hit_ok_reg || own_idx_reg != hit_idx_reg))
                            begin
                                state_reg <= S_OUT;
                            end
                            else if (!hit_ok_reg)
                            begin
                                if (cnt_reg < CNT_W'(LEASE_SLOTS))
                                begin
                                    we_mac_reg  <= 1'b1;
                                    we_addr_reg <= 1'b1;
                                    wr_idx_reg  <= cnt_reg[IDX_W-1:0];
                                    wr_mac_reg  <= mac_reg;
                                    wr_addr_reg <= addr_reg;
                                    cnt_reg     <= cnt_reg + CNT_W'(1);
                                    res_acc_reg <= 1'b1;
                                    state_reg   <= S_WRITE;
                                end
                                else
                                begin
                                    state_reg <= S_OUT;
                                end
                            end
                            else
                            begin
                                we_mac_reg  <= 1'b0;
                                we_addr_reg <= 1'b1;
                                wr_idx_reg  <= hit_idx_reg;
                                wr_addr_reg <= addr_reg;
                                res_acc_reg <= 1'b1;
                                state_reg   <= S_WRITE;
                            end
                        end
                        P_REM:
                        begin
                            if (hit_ok_reg)
                            begin
                                cnt_reg     <= cnt_reg - CNT_W'(1);
                                res_acc_reg <= 1'b1;
                                state_reg   <= S_MOVE;
                            end
                            else
                            begin
                                state_reg <= S_OUT;
                            end
                        end
                        default: state_reg <= S_OUT;
                    endcase
                end
                S_POOL:
                begin
                    // skip the server address, else scan the table for the candidate
                    if (cand_reg == cfg.srv_ip)
                    begin
                        if (cand_reg == cfg.pool_hi)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            cand_reg <= cand_reg + 32'd1;
                        end
                    end
                    else
                    begin
                        phase_reg <= P_POOL;
                        idx_reg   <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_MOVE:
                begin
                    // last entry is being read
                    state_reg <= S_MOVE2;
                end
                S_MOVE2:
                begin
                    we_mac_reg  <= 1'b1;
                    we_addr_reg <= 1'b1;
                    wr_idx_reg  <= hit_idx_reg;
                    wr_mac_reg  <= rd_mac_reg;
                    wr_addr_reg <= rd_addr_reg;
                    state_reg   <= S_WRITE;
                end
                S_WRITE:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_acc_reg   <= res_acc_reg;
                        out_type_reg  <= res_type_reg;
                        out_xid_reg   <= (res_type_reg != dla_pkg::RPL_NONE) ? xid_reg : '0;
                        out_mac_reg   <= (res_type_reg != dla_pkg::RPL_NONE) ? mac_reg : '0;
                        out_lease_reg <= res_lease_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // table never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(LEASE_SLOTS))
        else $error("lease count above table size");

    // count moves by at most one per step
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == $past(cnt_reg)) || (cnt_reg == $past(cnt_reg) + CNT_W'(1))
        || (cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("lease count jumped");

    // memory writes stay inside the packed table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> ({1'b0, wr_idx_reg} < {1'b0, cnt_reg}) ||
        (state_reg == S_WRITE && we_mac_reg && we_addr_reg
         && CNT_W'(wr_idx_reg) == cnt_reg))
        else $error("lease write outside packed table");

    // a successful remove shrinks the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_END && phase_reg == P_REM && hit_ok_reg)
        |=> (cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("remove did not shrink table");
`endif

endmodule

[dv/dla_lease_checker.sv]
`timescale 1ns / 1ps
// lease table checker: mirrors the register file, predicts each reply and compares beats
module dla_lease_checker #(
    parameter int LEASE_SLOTS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    dla_req_if                         req,
    dla_rsp_if                         rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dla_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    input  logic                       pready,
    output int                         mismatches,
    output int                         pending
);

    typedef struct packed {
        logic        accepted;
        logic [1:0]  reply_type;
        logic [31:0] reply_transaction;
        logic [47:0] reply_mac;
        logic [31:0] lease_address;
    } lease_reply_t;

    // mirrored configuration
    logic [31:0] srv_addr, pool_first, pool_last, net_mask, gw_addr;
    logic        svc_on;

    // mirrored lease table, packed below lease_cnt
    logic [47:0] mac_tab  [LEASE_SLOTS];
    logic [31:0] addr_tab [LEASE_SLOTS];
    int          lease_cnt;

    lease_reply_t reply_q[$];

    function automatic bit same_net(input logic [31:0] a);
        return (a & net_mask) == (srv_addr & net_mask);
    endfunction

    function automatic bit service_ready();
        logic [31:0] inv;
        inv = ~net_mask;
        if (!svc_on || srv_addr == 32'd0) return 0;
        if (pool_first > pool_last) return 0;
        if ((inv & (inv + 32'd1)) != 32'd0) return 0;
        if (!same_net(pool_first) || !same_net(pool_last)) return 0;
        if (gw_addr != 32'd0 && !same_net(gw_addr)) return 0;
        return 1;
    endfunction

    function automatic bit in_pool(input logic [31:0] a);
        return a >= pool_first && a <= pool_last && a != srv_addr;
    endfunction

    function automatic int slot_of_mac(input logic [47:0] mac);
        for (int i = 0; i < lease_cnt; i++)
            if (mac_tab[i] == mac) return i;
        return -1;
    endfunction

    function automatic int slot_of_addr(input logic [31:0] a);
        for (int i = 0; i < lease_cnt; i++)
            if (addr_tab[i] == a) return i;
        return -1;
    endfunction

    // existing lease, else lowest free pool address; scan stops at the pool top
    function automatic int offer_slot(input logic [47:0] mac);
        int          s;
        logic [31:0] a;
        s = slot_of_mac(mac);
        if (s >= 0) return s;
        a = pool_first;
        forever
        begin
            if (in_pool(a) && slot_of_addr(a) < 0)
            begin
                if (lease_cnt >= LEASE_SLOTS) return -1;
                mac_tab[lease_cnt]  = mac;
                addr_tab[lease_cnt] = a;
                lease_cnt++;
                return lease_cnt - 1;
            end
            if (a == pool_last) return -1;
            a++;
        end
    endfunction

    function automatic lease_reply_t predict_reply(input logic [1:0] op,
                                                   input logic [47:0] mac,
                                                   input logic [31:0] adr,
                                                   input logic [31:0] sid,
                                                   input logic [31:0] xid);
        lease_reply_t r;
        int           s;
        int           o;
        r = '0;
        if (op == dla_pkg::OP_REMOVE)
        begin
            s = slot_of_addr(adr);
            if (s >= 0)
            begin
                lease_cnt--;
                mac_tab[s]  = mac_tab[lease_cnt];
                addr_tab[s] = addr_tab[lease_cnt];
                r.accepted  = 1'b1;
            end
        end
        else if (service_ready())
        begin
            if (op == dla_pkg::OP_DISCOVER)
            begin
                s = offer_slot(mac);
                if (s >= 0)
                begin
                    r.accepted      = 1'b1;
                    r.reply_type    = dla_pkg::RPL_OFFER;
                    r.lease_address = addr_tab[s];
                end
            end
            else if (op == dla_pkg::OP_REQUEST)
            begin
                if (sid == srv_addr)
                begin
                    s = slot_of_mac(mac);
                    r.accepted = 1'b1;
                    if (s >= 0 && addr_tab[s] == adr)
                    begin
                        r.reply_type    = dla_pkg::RPL_ACK;
                        r.lease_address = adr;
                    end
                    else
                        r.reply_type = dla_pkg::RPL_NAK;
                end
            end
            else if (in_pool(adr))
            begin
                o = slot_of_addr(adr);
                s = slot_of_mac(mac);
                if (!(o >= 0 && o != s))
                begin
                    if (s < 0 && lease_cnt < LEASE_SLOTS)
                    begin
                        s = lease_cnt;
                        mac_tab[s] = mac;
                        lease_cnt++;
                    end
                    if (s >= 0)
                    begin
                        addr_tab[s] = adr;
                        r.accepted  = 1'b1;
                    end
                end
            end
        end
        if (r.reply_type != dla_pkg::RPL_NONE)
        begin
            r.reply_transaction = xid;
            r.reply_mac         = mac;
        end
        return r;
    endfunction

    // watch register writes, request beats and reply beats
    always @(posedge clk or negedge rst_n)
    begin
        lease_reply_t exp_r;
        lease_reply_t got_r;
        if (!rst_n)
        begin
            srv_addr   = '0;
            pool_first = '0;
            pool_last  = '0;
            net_mask   = '0;
            gw_addr    = '0;
            svc_on     = 1'b0;
            lease_cnt  = 0;
            reply_q.delete();
            pending    = 0;
            mismatches = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    dla_pkg::REG_SERVER:  srv_addr   = pwdata;
                    dla_pkg::REG_FIRST:   pool_first = pwdata;
                    dla_pkg::REG_LAST:    pool_last  = pwdata;
                    dla_pkg::REG_MASK:    net_mask   = pwdata;
                    dla_pkg::REG_GATEWAY: gw_addr    = pwdata;
                    dla_pkg::REG_ENABLE:  svc_on     = pwdata[0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
                reply_q.push_back(predict_reply(req.op, req.hw_addr, req.address,
                                                req.server_id, req.xact_id));
            if (rsp.valid && rsp.ready)
            begin
                got_r = '{rsp.accepted, rsp.reply_type, rsp.reply_transaction,
                          rsp.reply_mac, rsp.lease_address};
                if (reply_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply beat with nothing expected: %h", got_r);
                end
                else
                begin
                    exp_r = reply_q.pop_front();
                    if (exp_r.accepted != got_r.accepted
                        || exp_r.reply_type != got_r.reply_type
                        || exp_r.reply_transaction != got_r.reply_transaction
                        || exp_r.reply_mac != got_r.reply_mac
                        || exp_r.lease_address != got_r.lease_address)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"reply mismatch: exp acc %0d type %0d xid %h mac %h ",
                                      "lease %h / got acc %0d type %0d xid %h mac %h lease %h"},
                                     exp_r.accepted, exp_r.reply_type, exp_r.reply_transaction,
                                     exp_r.reply_mac, exp_r.lease_address,
                                     got_r.accepted, got_r.reply_type, got_r.reply_transaction,
                                     got_r.reply_mac, got_r.lease_address);
                    end
                end
            end
            pending = reply_q.size();
        end
    end

endmodule

[dv/tb_dhcp_lease_allocator_top.sv]
`timescale 1ns / 1ps
// testbench top: clock, reset, register writes, lease traffic and verdict
module tb_dhcp_lease_allocator_top;

    logic                        clk;
    logic                        rst_n;
    logic                        psel, penable, pwrite;
    logic [dla_pkg::ADDR_W-1:0]  paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    int                          mismatches;
    int                          pending;

    dla_req_if req ();
    dla_rsp_if rsp ();

    dhcp_lease_allocator_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dla_lease_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // stimulus-side bookkeeping
    int          ops_sent;
    int          replies_seen = 0;
    logic [31:0] last_lease;
    int          burst_left;
    logic [47:0] client_pool [100];
    logic [31:0] cur_server, cur_first, cur_last;

    // receiver stall state
    logic [15:0] stall_cyc  = '0;
    logic [1:0]  stall_mode = 2'd0;
    logic [15:0] stall_pat  = 16'hffff;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // overall time limit
    initial
    begin
        #400_000_000;
        $display("tb_dhcp_lease_allocator_top: done, errors");
        $finish;
    end

    // reply counter and lease address of the last reply
    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
        begin
            replies_seen = replies_seen + 1;
            last_lease   = rsp.lease_address;
        end
    end

    // receiver: stall style changes whenever the low byte of the stall counter is zero
    always @(posedge clk)
    begin
        stall_cyc <= stall_cyc + 16'd1;
        if (stall_cyc[7:0] == 8'd0)
        begin
            stall_mode <= 2'($urandom_range(0, 2));
            stall_pat  <= 16'($urandom);
        end
        case (stall_mode)
            2'd0:    rsp.ready <= 1'b1;
            2'd1:    rsp.ready <= 1'($urandom_range(0, 1));
            default: rsp.ready <= stall_pat[stall_cyc[3:0]];
        endcase
    end

    // one request beat; bursts of random length with random gaps
    task automatic send_lease_op(input logic [1:0] op, input logic [47:0] mac,
                                 input logic [31:0] adr, input logic [31:0] sid,
                                 input logic [31:0] xid);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        req.valid     <= 1'b1;
        req.op        <= op;
        req.hw_addr   <= mac;
        req.address   <= adr;
        req.server_id <= sid;
        req.xact_id   <= xid;
        do
            @(posedge clk);
        while (!req.ready);
        ops_sent++;
    endtask

    // stop sending and let every outstanding reply arrive
    task automatic drain_replies();
        req.valid <= 1'b0;
        @(posedge clk);
        while (replies_seen != ops_sent || pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_pool_cfg(input logic [31:0] srv, input logic [31:0] first,
                                 input logic [31:0] last, input logic [31:0] mask,
                                 input logic [31:0] gw, input logic en);
        drain_replies();
        reg_write(dla_pkg::REG_SERVER, srv);
        reg_write(dla_pkg::REG_FIRST, first);
        reg_write(dla_pkg::REG_LAST, last);
        reg_write(dla_pkg::REG_MASK, mask);
        reg_write(dla_pkg::REG_GATEWAY, gw);
        reg_write(dla_pkg::REG_ENABLE, {31'($urandom) << 1, en});
        cur_server = srv;
        cur_first  = first;
        cur_last   = last;
    endtask

    // an address near the bottom of the current pool, rarely anywhere at all
    function automatic logic [31:0] pick_pool_addr();
        logic [31:0] span;
        span = cur_last - cur_first;
        if (cur_last < cur_first || $urandom_range(0, 19) == 0) return $urandom;
        if (span > 32'd90) span = 32'd90;
        return cur_first + $urandom_range(0, span);
    endfunction

    function automatic logic [47:0] pick_client();
        if ($urandom_range(0, 9) == 0) return {16'($urandom), 32'($urandom)};
        return client_pool[$urandom_range(0, 99)];
    endfunction

    // discover, wait for the offer, then request the offered address
    task automatic offer_and_claim(input logic [47:0] mac);
        send_lease_op(dla_pkg::OP_DISCOVER, mac, $urandom, $urandom, $urandom);
        drain_replies();
        send_lease_op(dla_pkg::OP_REQUEST, mac, last_lease, cur_server, $urandom);
    endtask

    // random traffic over the current settings; grow keeps removes rare
    task automatic run_traffic(input int n_ops, input bit grow);
        int sel;
        int rm_pct;
        rm_pct = grow ? 5 : 35;
        for (int i = 0; i < n_ops; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < rm_pct)
                send_lease_op(dla_pkg::OP_REMOVE, pick_client(), pick_pool_addr(),
                              $urandom, $urandom);
            else if (sel < rm_pct + 30)
            begin
                offer_and_claim(pick_client());
                i++;
            end
            else if (sel < rm_pct + 45)
                send_lease_op(dla_pkg::OP_DISCOVER, pick_client(), $urandom, $urandom,
                              $urandom);
            else if (sel < rm_pct + 57)
                send_lease_op(dla_pkg::OP_RESERVE, pick_client(), pick_pool_addr(), $urandom,
                              $urandom);
            else if (sel < rm_pct + 62)
                send_lease_op(2'($urandom), {16'($urandom), 32'($urandom)}, $urandom,
                              $urandom, $urandom);
            else
                send_lease_op(dla_pkg::OP_REQUEST, pick_client(), pick_pool_addr(),
                              ($urandom_range(0, 7) == 0) ? $urandom : cur_server, $urandom);
        end
    endtask

    initial
    begin
        logic [31:0] f;
        logic [31:0] s;
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        req.valid     <= 1'b0;
        req.op        <= dla_pkg::OP_DISCOVER;
        req.hw_addr   <= '0;
        req.address   <= '0;
        req.server_id <= '0;
        req.xact_id   <= '0;
        ops_sent   = 0;
        burst_left = 0;
        cur_server = '0;
        cur_first  = '0;
        cur_last   = '0;
        for (int i = 0; i < 100; i++)
            client_pool[i] = {16'($urandom), 32'($urandom)};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // service off after reset: everything refused, remove on an empty table
        send_lease_op(dla_pkg::OP_DISCOVER, client_pool[0], 32'h0, 32'h0, 32'h0);
        send_lease_op(dla_pkg::OP_REQUEST, client_pool[0], 32'h0, 32'h0, 32'hffff_ffff);
        send_lease_op(dla_pkg::OP_RESERVE, client_pool[0], 32'h0a00_0003, 32'h0, 32'h1);
        send_lease_op(dla_pkg::OP_REMOVE, client_pool[0], 32'h0a00_0003, 32'h0, 32'h2);

        // small subnet with the server inside the pool
        load_pool_cfg(32'h0a00_0005, 32'h0a00_0003, 32'h0a00_0040, 32'hffff_ff00,
                      32'h0a00_0001, 1'b1);
        send_lease_op(dla_pkg::OP_DISCOVER, client_pool[0], 32'h0, 32'h0, 32'h0);
        send_lease_op(dla_pkg::OP_DISCOVER, client_pool[0], 32'h0, 32'h0, 32'hffff_ffff);
        send_lease_op(dla_pkg::OP_DISCOVER, client_pool[1], 32'h0, 32'h0, 32'h11);
        // next free address is the server, so it is skipped
        send_lease_op(dla_pkg::OP_DISCOVER, client_pool[2], 32'h0, 32'h0, 32'h12);
        send_lease_op(dla_pkg::OP_DISCOVER, 48'hffff_ffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                      32'h13);
        send_lease_op(dla_pkg::OP_REQUEST, client_pool[0], 32'h0a00_0003, 32'h0a00_0005,
                      32'h20);
        send_lease_op(dla_pkg::OP_REQUEST, client_pool[0], 32'h0a00_0004, 32'h0a00_0005,
                      32'h21);
        send_lease_op(dla_pkg::OP_REQUEST, client_pool[0], 32'h0a00_0003, 32'h0a00_0006,
                      32'h22);
        send_lease_op(dla_pkg::OP_REQUEST, client_pool[9], 32'h0, 32'h0a00_0005, 32'h23);
        send_lease_op(dla_pkg::OP_RESERVE, client_pool[3], 32'h0a00_0004, 32'h0, 32'h30);
        send_lease_op(dla_pkg::OP_RESERVE, client_pool[3], 32'h0a00_0005, 32'h0, 32'h31);
        send_lease_op(dla_pkg::OP_RESERVE, client_pool[3], 32'h0a00_0041, 32'h0, 32'h32);
        send_lease_op(dla_pkg::OP_RESERVE, client_pool[3], 32'h0a00_0010, 32'h0, 32'h33);
        send_lease_op(dla_pkg::OP_RESERVE, client_pool[0], 32'h0a00_0011, 32'h0, 32'h34);
        send_lease_op(dla_pkg::OP_REMOVE, client_pool[0], 32'h0a00_0004, 32'h0, 32'h40);
        send_lease_op(dla_pkg::OP_REMOVE, client_pool[0], 32'h0a00_0004, 32'h0, 32'h41);
        send_lease_op(dla_pkg::OP_DISCOVER, client_pool[4], 32'h0, 32'h0, 32'h42);
        run_traffic(180, 1'b0);

        // top of the address space with an empty mask; table fills up
        load_pool_cfg(32'hffff_ffff, 32'hffff_ff00, 32'hffff_ffff, 32'h0, 32'h0, 1'b1);
        run_traffic(120, 1'b1);

        // remove works with the service off
        load_pool_cfg(32'hffff_ffff, 32'hffff_ff00, 32'hffff_ffff, 32'h0, 32'h0, 1'b0);
        run_traffic(60, 1'b0);

        // single-address pool equal to the server: no free address ever
        load_pool_cfg(32'hc0a8_0101, 32'hc0a8_0101, 32'hc0a8_0101, 32'hffff_ffff,
                      32'hc0a8_0101, 1'b1);
        run_traffic(40, 1'b0);

        // pool starting at address zero
        load_pool_cfg(32'h0000_0020, 32'h0, 32'h0000_003f, 32'hffff_ff00, 32'h0, 1'b1);
        run_traffic(180, 1'b0);

        // broken settings: mask with a hole, gateway off-net, inverted pool, no server
        load_pool_cfg(32'h0a00_0005, 32'h0a00_0003, 32'h0a00_0040, 32'hff00_ff00,
                      32'h0, 1'b1);
        run_traffic(15, 1'b0);
        load_pool_cfg(32'h0a00_0005, 32'h0a00_0003, 32'h0a00_0040, 32'hffff_ff00,
                      32'h0b00_0001, 1'b1);
        run_traffic(15, 1'b0);
        load_pool_cfg(32'h0a00_0005, 32'h0a00_0040, 32'h0a00_0003, 32'hffff_ff00,
                      32'h0, 1'b1);
        run_traffic(15, 1'b0);
        load_pool_cfg(32'h0, 32'h0a00_0003, 32'h0a00_0040, 32'hffff_ff00, 32'h0, 1'b1);
        run_traffic(15, 1'b0);

        // random settings: wide-open mask with a random narrow pool, then pure noise
        for (int p = 0; p < 6; p++)
        begin
            if (p < 4)
            begin
                f = $urandom;
                if (f > 32'hffff_ff00) f = 32'hffff_ff00;
                s = f + $urandom_range(0, 150);
                load_pool_cfg(s | 32'h1, f, f + $urandom_range(0, 200), 32'h0,
                              ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom, 1'b1);
            end
            else
                load_pool_cfg($urandom, $urandom, $urandom, $urandom, $urandom,
                              1'($urandom));
            run_traffic(40, 1'b0);
        end

        // let everything land, then the verdict
        drain_replies();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb_dhcp_lease_allocator_top: done, clean");
        else
            $display("tb_dhcp_lease_allocator_top: done, errors");
        $finish;
    end

endmodule
